@@ hw/rtl/pcpa_pkg.sv @@
package pcpa_pkg;

  localparam int CPU_COUNT  = 8;
  localparam int CPU_W      = 3;
  localparam int VIC_W      = 5;
  localparam int MAX_PAGES  = 32768;
  localparam int PAGE_SHIFT = 12;
  localparam int IDX_W      = $clog2(MAX_PAGES);
  localparam int LINK_W     = $clog2(MAX_PAGES + 1);
  localparam logic [LINK_W-1:0] NIL = LINK_W'(MAX_PAGES);

  localparam logic [1:0] CFG_LOWER = 2'd0;
  localparam logic [1:0] CFG_UPPER = 2'd1;
  localparam logic [1:0] CFG_BATCH = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOPAGE  = 2'd1;
  localparam logic [1:0] ST_BADADDR = 2'd2;

  typedef enum logic [1:0] {
    K_FREE,
    K_BAD,
    K_ALLOC,
    K_NOPAGE
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CPU_W-1:0]  cpu;
    logic [IDX_W-1:0]  idx;
  } op_t;

endpackage

@@ hw/rtl/pcpa_ram.sv @@
module pcpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/pcpa_front.sv @@
module pcpa_front
  import pcpa_pkg::*;
(
  input  logic [0:0]  cmd,
  input  logic [2:0]  cpu,
  input  logic [31:0] addr,
  input  logic [31:0] lower_bound,
  input  logic [31:0] upper_bound,
  input  logic [31:0] base,
  output op_t         op
);

  logic        cpu_bad;
  logic        range_bad;
  logic [31:0] diff;
  logic [31-PAGE_SHIFT:0] idx_full;

  always_comb begin
    cpu_bad   = 32'({1'b0, cpu}) >= 32'(CPU_COUNT);
    range_bad = (addr[PAGE_SHIFT-1:0] != '0) || (addr < lower_bound) ||
                (addr >= upper_bound);
    diff      = addr - base;
    idx_full  = diff[31:PAGE_SHIFT];
    op.cpu    = cpu[CPU_W-1:0];
    op.idx    = idx_full[IDX_W-1:0];
    if (cmd == 1'b1) begin
      op.kind = cpu_bad ? K_NOPAGE : K_ALLOC;
    end else if (cpu_bad || range_bad || (32'(idx_full) >= 32'(MAX_PAGES))) begin
      op.kind = K_BAD;
    end else begin
      op.kind = K_FREE;
    end
  end

endmodule

@@ hw/rtl/pcpa_fifo.sv @@
module pcpa_fifo
  import pcpa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_data,
  input  logic pop,
  output op_t  pop_data,
  output logic full,
  output logic empty
);

  op_t        slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = count == 2'd2;
  assign empty    = count == 2'd0;
  assign pop_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ hw/rtl/pcpa_back.sv @@
module pcpa_back
  import pcpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  op_t         op,
  input  logic        op_avail,
  output logic        op_take,
  input  logic [31:0] base,
  input  logic [15:0] steal_batch,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] page_addr
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_STEAL_WR,
    S_POP,
    S_POP_WR
  } state_t;

  state_t            state;
  logic [LINK_W-1:0] heads [CPU_COUNT];
  logic [CPU_W-1:0]  cur_cpu;
  logic [VIC_W-1:0]  vic;
  logic [15:0]       left;

  logic              out_free;
  logic [CPU_W-1:0]  vic_idx;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [LINK_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [LINK_W-1:0] ram_rdata;
  logic [31:0]       pop_addr;

  assign out_free = !out_valid || !out_stall;
  assign op_take  = (state == S_IDLE) && op_avail && out_free;
  assign vic_idx  = vic[CPU_W-1:0];
  assign pop_addr = base + (32'(heads[cur_cpu][IDX_W-1:0]) << PAGE_SHIFT);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = op.idx;
    ram_wdata = heads[op.cpu];
    ram_raddr = heads[cur_cpu][IDX_W-1:0];
    case (state)
      S_IDLE: begin
        ram_we = op_take && (op.kind == K_FREE);
      end
      S_SCAN: begin
        ram_raddr = heads[vic_idx][IDX_W-1:0];
      end
      S_STEAL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = heads[vic_idx][IDX_W-1:0];
        ram_wdata = heads[cur_cpu];
      end
      default: begin
      end
    endcase
  end

  pcpa_ram #(.WIDTH(LINK_W), .DEPTH(MAX_PAGES)) u_link (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < CPU_COUNT; i++) heads[i] <= NIL;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (op_take) begin
            cur_cpu <= op.cpu;
            case (op.kind)
              K_FREE: begin
                heads[op.cpu] <= LINK_W'(op.idx);
                out_valid     <= 1'b1;
                status        <= ST_OK;
                page_addr     <= '0;
              end
              K_BAD: begin
                out_valid <= 1'b1;
                status    <= ST_BADADDR;
                page_addr <= '0;
              end
              K_NOPAGE: begin
                out_valid <= 1'b1;
                status    <= ST_NOPAGE;
                page_addr <= '0;
              end
              default: begin
                vic   <= '0;
                left  <= steal_batch;
                state <= (heads[op.cpu] == NIL) ? S_SCAN : S_POP;
              end
            endcase
          end
        end
        S_SCAN: begin
          if ((left == '0) || (vic == VIC_W'(CPU_COUNT))) begin
            state <= S_POP;
          end else if ((vic_idx == cur_cpu) || (heads[vic_idx] == NIL)) begin
            vic <= vic + 1'b1;
          end else begin
            state <= S_STEAL_WR;
          end
        end
        S_STEAL_WR: begin
          // victim head moves onto own list, victim takes its successor
          heads[cur_cpu] <= heads[vic_idx];
          heads[vic_idx] <= ram_rdata;
          left           <= left - 1'b1;
          state          <= S_SCAN;
        end
        S_POP: begin
          if (heads[cur_cpu] == NIL) begin
            out_valid <= 1'b1;
            status    <= ST_NOPAGE;
            page_addr <= '0;
            state     <= S_IDLE;
          end else begin
            state <= S_POP_WR;
          end
        end
        S_POP_WR: begin
          heads[cur_cpu] <= ram_rdata;
          out_valid      <= 1'b1;
          status         <= ST_OK;
          page_addr      <= pop_addr;
          state          <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_out_empty: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !out_valid)
    else $error("result register busy during list walk");

  a_left_dec: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEAL_WR) |=> (left == $past(left) - 16'd1))
    else $error("steal count not decremented");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (heads[cur_cpu] <= NIL))
    else $error("list head out of range");

endmodule

@@ hw/rtl/per_cpu_page_allocator_with_steal.sv @@
// Per-CPU page allocator with stealing.
// Input channel (in_valid/in_stall): cmd, cpu, addr. cmd 0 frees the page at
// addr onto cpu's list, cmd 1 allocates from cpu's list. One result per item
// on the output channel (out_valid/out_stall): status and page_addr.
// Config: cfg_we with cfg_index (0 lower bound, 1 upper bound, 2 steal batch)
// and cfg_data; the user writes them only while idle, the block does not check.
// Flow: a classified item waits in a two-entry queue; the back end answers a
// free or rejected item straight from idle, pops a non-empty list in a read
// and a write state, and for an empty list first scans the other CPUs,
// stealing each page in a scan and a write state. The link RAM has one read
// and one write port and a registered read. The result is registered in the
// final state. Throughput: one free or rejected item per cycle while out_stall
// is low; an allocate holds the back end, which takes no new item until done.
// Reset empties all lists and loads the register defaults; link RAM content
// is left as is, since only pushed pages are ever followed.
// While the receiver stalls, the result holds; the queue keeps taking input
// until full, then in_stall rises.
module per_cpu_page_allocator_with_steal
  import pcpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [0:0]  cmd,
  input  logic [2:0]  cpu,
  input  logic [31:0] addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] page_addr,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] lower_bound;
  logic [31:0] upper_bound;
  logic [15:0] steal_batch;
  logic [31:0] base;
  op_t         front_op;
  op_t         q_op;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_bound <= 32'h8000_0000;
      upper_bound <= 32'h8800_0000;
      steal_batch <= 16'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOWER: lower_bound <= cfg_data;
        CFG_UPPER: upper_bound <= cfg_data;
        CFG_BATCH: steal_batch <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // lower bound rounded up to a page boundary
  assign base = (lower_bound + 32'((1 << PAGE_SHIFT) - 1)) &
                ~32'((1 << PAGE_SHIFT) - 1);

  assign in_stall = q_full;

  pcpa_front u_front (
    .cmd         (cmd),
    .cpu         (cpu),
    .addr        (addr),
    .lower_bound (lower_bound),
    .upper_bound (upper_bound),
    .base        (base),
    .op          (front_op)
  );

  pcpa_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && !q_full),
    .push_data (front_op),
    .pop       (q_pop),
    .pop_data  (q_op),
    .full      (q_full),
    .empty     (q_empty)
  );

  pcpa_back u_back (
    .clk         (clk),
    .rst         (rst),
    .op          (q_op),
    .op_avail    (!q_empty),
    .op_take     (q_pop),
    .base        (base),
    .steal_batch (steal_batch),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .page_addr   (page_addr)
  );

endmodule

@@ sim/testbench.sv @@
module testbench;
  import pcpa_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [0:0]  cmd;
  logic [2:0]  cpu;
  logic [31:0] addr;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [31:0] page_addr;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] page_addr;
  } alloc_result_t;

  // Scoreboard: mirrors the free lists and queues the expected replies.
  class page_scoreboard;
    logic [31:0]       lower_bound;
    logic [31:0]       upper_bound;
    logic [15:0]       steal_batch;
    logic [LINK_W-1:0] links [MAX_PAGES];
    logic [LINK_W-1:0] heads [CPU_COUNT];
    alloc_result_t     pending[$];
    int                errors;

    function void clear();
      lower_bound = 32'h8000_0000;
      upper_bound = 32'h8800_0000;
      steal_batch = 16'd64;
      foreach (heads[i]) heads[i] = NIL;
      pending.delete();
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] index, logic [31:0] value);
      case (index)
        CFG_LOWER: lower_bound = value;
        CFG_UPPER: upper_bound = value;
        CFG_BATCH: steal_batch = value[15:0];
        default: ;
      endcase
    endfunction

    function logic [LINK_W-1:0] take_head(int c);
      logic [LINK_W-1:0] p;
      p = heads[c];
      if (p < NIL) heads[c] = links[p];
      return p;
    endfunction

    function void put_head(int c, logic [LINK_W-1:0] p);
      links[p] = heads[c];
      heads[c] = p;
    endfunction

    function void note_transfer(logic [0:0] k, logic [2:0] c, logic [31:0] a);
      logic [32:0]       base;
      logic [32:0]       idx;
      logic [LINK_W-1:0] p;
      alloc_result_t     r;
      int                left;
      base = ({1'b0, lower_bound} + 33'hFFF) & ~33'hFFF;
      r.status = ST_OK;
      r.page_addr = '0;
      if (k == 1'b0) begin
        idx = ({1'b0, a} - base) >> PAGE_SHIFT;
        if (a[11:0] != 0 || a < lower_bound || a >= upper_bound || idx >= MAX_PAGES)
          r.status = ST_BADADDR;
        else
          put_head(c, idx[LINK_W-1:0]);
      end else begin
        if (heads[c] >= NIL) begin
          left = steal_batch;
          for (int v = 0; v < CPU_COUNT && left != 0; v++) begin
            if (v == c) continue;
            while (left != 0 && heads[v] < NIL) begin
              put_head(c, take_head(v));
              left--;
            end
          end
        end
        p = take_head(c);
        if (p >= NIL) r.status = ST_NOPAGE;
        else r.page_addr = 32'(base + (33'(p) << PAGE_SHIFT));
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [31:0] pa);
      alloc_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result status=%0d page_addr=%h", st, pa);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
        $error("status expected %0d actual %0d", e.status, st);
        errors++;
      end
      if (pa !== e.page_addr) begin
        $error("page_addr expected %h actual %h", e.page_addr, pa);
        errors++;
      end
    endfunction
  endclass

  page_scoreboard sb;
  int send_idle;   // percent
  int recv_stall;  // percent
  int page_span;   // pages used for random frees

  per_cpu_page_allocator_with_steal u_dut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200000000;
    $display("CHECK FAILED");
    $finish;
  end

  // receiver side: random stall, check on each transfer
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_result(status, page_addr);
      out_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  // valid stays high between back-to-back transfers; it drops only when idling
  task automatic send(logic [0:0] k, logic [2:0] c, logic [31:0] a);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= k;
    cpu <= c;
    addr <= a;
    do @(posedge clk); while (in_stall);
    sb.note_transfer(k, c, a);
  endtask

  task automatic write_reg(logic [1:0] index, logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(index, value);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] page_of(int n);
    return ((sb.lower_bound + 32'hFFF) & ~32'hFFF) + (n << PAGE_SHIFT);
  endfunction

  task automatic random_phase(int n, int idle, int stall);
    send_idle = idle;
    recv_stall = stall;
    for (int i = 0; i < n; i++) begin
      int sel;
      sel = $urandom_range(99);
      if (sel < 45)
        send(1'b0, 3'($urandom), page_of($urandom_range(page_span - 1)));
      else if (sel < 90)
        send(1'b1, 3'($urandom), $urandom);
      else if (sel < 95)
        send(1'b0, 3'($urandom), $urandom);
      else
        send(1'b0, 3'($urandom),
             page_of($urandom_range(page_span - 1)) | $urandom_range(4095));
    end
    drain();
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = '0;
    cpu = '0;
    addr = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_LOWER;
    cfg_data = '0;
    send_idle = 0;
    recv_stall = 0;
    page_span = 64;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty allocs, bounds edges, misalignment, steal
    send(1'b1, 3'd0, 32'h0);
    send(1'b0, 3'd0, 32'h8000_0000);
    send(1'b0, 3'd1, 32'h8000_1000);
    send(1'b0, 3'd7, 32'h87FF_F000);
    send(1'b0, 3'd2, 32'h8800_0000);
    send(1'b0, 3'd2, 32'h7FFF_F000);
    send(1'b0, 3'd2, 32'h8000_2001);
    send(1'b0, 3'd2, 32'hFFFF_FFFF);
    send(1'b0, 3'd2, 32'h0000_0000);
    send(1'b1, 3'd7, 32'hFFFF_FFFF);
    send(1'b1, 3'd3, 32'h0);
    send(1'b1, 3'd3, 32'h0);
    send(1'b1, 3'd3, 32'h0);
    send(1'b1, 3'd3, 32'h0);
    send(1'b0, 3'd5, 32'h8000_3000);
    send(1'b0, 3'd5, 32'h8000_3000);  // double free
    send(1'b1, 3'd5, 32'h0);
    send(1'b1, 3'd5, 32'h0);
    drain();

    // base rounding, small batch, last page index within capacity
    write_reg(CFG_LOWER, 32'h0000_0001);
    write_reg(CFG_UPPER, 32'hFFFF_FFFF);
    write_reg(CFG_BATCH, 32'd1);
    send(1'b0, 3'd1, 32'h0000_1000);
    send(1'b0, 3'd2, 32'h0800_0000);  // last index within capacity
    send(1'b0, 3'd2, 32'h07FF_F000);
    send(1'b0, 3'd4, 32'h0000_0000);
    send(1'b1, 3'd0, 32'h0);
    send(1'b1, 3'd0, 32'h0);
    send(1'b1, 3'd6, 32'h0);
    drain();

    write_reg(CFG_LOWER, 32'h8000_0000);
    write_reg(CFG_UPPER, 32'h8800_0000);
    random_phase(400, 0, 0);
    write_reg(CFG_BATCH, 32'd32768);
    write_reg(CFG_UPPER, 32'h8003_0000);
    random_phase(400, 71, 0);
    write_reg(CFG_BATCH, 32'd2);
    write_reg(CFG_LOWER, 32'hFFFC_0000);
    write_reg(CFG_UPPER, 32'hFFFF_FFFF);
    random_phase(400, 0, 71);
    write_reg(CFG_BATCH, 32'd0);
    write_reg(CFG_LOWER, 32'h0000_0000);
    write_reg(CFG_UPPER, 32'h0004_0000);
    random_phase(150, 8, 8);
    write_reg(CFG_BATCH, 32'd64);
    write_reg(CFG_UPPER, 32'h0000_0000);
    random_phase(50, 8, 8);
    write_reg(CFG_UPPER, 32'h0010_0000);
    page_span = 256;
    random_phase(350, 8, 8);

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
